[rtl/core/cles_pkg.sv]
// Package: shared types and constants for the command line editor and scanner.
`timescale 1ns / 1ps
package cles_pkg;
    localparam int LINE_CAPACITY_DEF = 32;
    localparam logic [7:0] ESCAPE_RESET = 8'd27;

    localparam logic [1:0] ACT_RX  = 2'd0;
    localparam logic [1:0] ACT_CMD = 2'd1;
    localparam logic [1:0] ACT_INT = 2'd2;

    localparam logic [1:0] ECHO_NONE  = 2'd0;
    localparam logic [1:0] ECHO_BYTE  = 2'd1;
    localparam logic [1:0] ECHO_ERASE = 2'd2;
    localparam logic [1:0] ECHO_NL    = 2'd3;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;

    typedef enum logic [3:0] {
        S_IDLE, S_RX, S_ERASE, S_CMD_RD, S_CMD_CHK, S_INT_RD, S_INT_CHK,
        S_NEG_RD, S_NEG_CHK, S_DIG_RD, S_DIG_CHK, S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;      // latch input transaction
        logic rx_exec;   // perform receive byte decision
        logic erase_one; // emit one erase result of an escape clear
        logic rd;        // issue store read at read position
        logic rd_next;   // issue store read at read position plus one
        logic adv;       // advance read position
        logic set_cmd;   // capture cmd result from read data
        logic cmd_end;   // command fetch hit end of line
        logic int_err;   // integer fetch error
        logic set_neg;   // sign seen, step over it
        logic acc;       // accumulate a digit
        logic int_fin;   // finish integer result
        logic out_load;  // present single result
        logic out_take;  // result transaction done
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       at_end;     // read position at line length
        logic       next_end;   // read position plus one at line length
        logic       is_blank;
        logic       is_digit;
        logic       is_dot;
        logic       is_dash;
        logic       esc_clear;  // receive byte is escape on non-empty line
        logic       erase_last; // one erase left
        logic       out_valid;
    } t_sts;

    function automatic logic f_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction
endpackage

[rtl/core/cles_ram.sv]
// Generic simple dual port RAM (separate write and read addresses) with registered read.
`timescale 1ns / 1ps
module cles_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/core/cles_ctrl.sv]
// Controller state machine sequencing receive, erase and fetch work.
`timescale 1ns / 1ps
module cles_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_out_ready,
    input  cles_pkg::t_sts  i_sts,
    output logic            o_ready,
    output cles_pkg::t_cmd  o_cmd
);
    import cles_pkg::*;
    t_state r_state, n_state;
    logic out_free;

    assign out_free = !i_sts.out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                n_state = S_RX;
            end
            S_RX: begin
                unique case (i_sts.action)
                    ACT_RX:  n_state = i_sts.esc_clear ? S_ERASE : S_OUT;
                    ACT_CMD: n_state = S_CMD_RD;
                    ACT_INT: n_state = S_INT_RD;
                    default: n_state = S_OUT;
                endcase
            end
            // the final erase result closes the transaction
            S_ERASE: if (out_free && i_sts.erase_last) n_state = S_IDLE;
            S_CMD_RD: n_state = S_CMD_CHK;
            S_CMD_CHK: n_state = (!i_sts.at_end && i_sts.is_blank) ? S_CMD_RD : S_OUT;
            S_INT_RD: n_state = S_INT_CHK;
            S_INT_CHK: begin
                priority if (i_sts.at_end || i_sts.is_dot) n_state = S_OUT;
                else if (i_sts.is_dash) n_state = S_NEG_RD;
                else if (i_sts.is_digit) n_state = S_DIG_CHK;
                else n_state = S_INT_RD;
            end
            S_NEG_RD: n_state = S_NEG_CHK;
            S_NEG_CHK: n_state = (i_sts.next_end || !i_sts.is_digit) ? S_OUT : S_DIG_RD;
            S_DIG_RD: n_state = S_DIG_CHK;
            S_DIG_CHK: n_state = (!i_sts.at_end && i_sts.is_digit) ? S_DIG_RD : S_OUT;
            S_OUT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.take = i_valid;
            end
            S_RX: begin
                o_cmd.rx_exec = (i_sts.action == ACT_RX);
                o_cmd.rd      = 1'b1;
            end
            S_ERASE: o_cmd.erase_one = out_free;
            S_CMD_RD: o_cmd.rd = 1'b1;
            S_CMD_CHK: begin
                priority if (i_sts.at_end) o_cmd.cmd_end = 1'b1;
                else if (i_sts.is_blank) o_cmd.adv = 1'b1;
                else begin
                    o_cmd.set_cmd = 1'b1;
                    o_cmd.adv     = 1'b1;
                end
            end
            S_INT_RD: o_cmd.rd = 1'b1;
            S_INT_CHK: begin
                priority if (i_sts.at_end || i_sts.is_dot) o_cmd.int_err = 1'b1;
                else if (i_sts.is_dash) o_cmd.rd_next = 1'b1;
                else if (i_sts.is_digit) o_cmd.rd = 1'b0;
                else o_cmd.adv = 1'b1;
            end
            // hold the read on the character after the sign
            S_NEG_RD: o_cmd.rd_next = 1'b1;
            S_NEG_CHK: begin
                if (i_sts.next_end || !i_sts.is_digit) o_cmd.int_err = 1'b1;
                else o_cmd.set_neg = 1'b1;
            end
            S_DIG_RD: o_cmd.rd = 1'b1;
            S_DIG_CHK: begin
                if (!i_sts.at_end && i_sts.is_digit) begin
                    o_cmd.acc = 1'b1;
                    o_cmd.adv = 1'b1;
                end else o_cmd.int_fin = 1'b1;
            end
            S_OUT: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_take = out_free;
            end
            default: ;
        endcase
    end
endmodule

[rtl/core/cles_dp.sv]
// Datapath: line store, counters, integer accumulator and result register.
`timescale 1ns / 1ps
module cles_dp #(
    parameter int LINE_CAPACITY = cles_pkg::LINE_CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_out_ready,
    input  cles_pkg::t_cmd    i_cmd,
    output cles_pkg::t_sts    o_sts,
    output logic              o_out_valid,
    output logic [1:0]        o_echo_kind,
    output logic [7:0]        o_echo_byte,
    output logic              o_line_done,
    output logic              o_escape_flag,
    output logic [7:0]        o_cmd_char,
    output logic signed [31:0] o_int_value,
    output logic              o_param_error,
    output logic              o_last
);
    import cles_pkg::*;
    localparam int AW = $clog2(LINE_CAPACITY);
    localparam int LW = $clog2(LINE_CAPACITY + 1);
    localparam logic [LW-1:0] CAP = LW'(LINE_CAPACITY);

    logic [7:0]    r_esc;
    logic [1:0]    r_action;
    logic [7:0]    r_byte;
    logic [LW-1:0] r_len, r_pos, r_erase;
    logic          r_complete;
    logic [32:0]   r_mag;
    logic          r_neg;
    logic [LW-1:0] eff_len, eff_pos;
    logic [7:0]    rdata;
    logic          we;
    logic [AW-1:0] raddr;
    logic [LW-1:0] pos_p1;

    // result holding registers
    logic [1:0]  r_kind;
    logic [7:0]  r_ebyte;
    logic        r_done, r_escf, r_perr;
    logic [7:0]  r_cmdc;
    logic [31:0] r_ival;
    logic        r_ovalid;

    // a completed line is dropped lazily by the next received byte
    assign eff_len = (r_complete && r_action == ACT_RX) ? '0 : r_len;
    assign eff_pos = (r_complete && r_action == ACT_RX) ? '0 : r_pos;
    assign pos_p1  = r_pos + LW'(1);

    assign we = i_cmd.rx_exec && r_byte != CH_CR && r_byte != CH_TAB && r_byte != CH_BS
                && r_byte != CH_LF && r_byte != r_esc && r_byte != CH_NUL && eff_len < CAP;
    assign raddr = i_cmd.rd_next ? pos_p1[AW-1:0] : r_pos[AW-1:0];

    cles_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(eff_len[AW-1:0]),
        .i_wdata(r_byte),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_sts.action     = r_action;
    assign o_sts.at_end     = (r_pos >= r_len);
    assign o_sts.next_end   = (pos_p1 >= r_len);
    assign o_sts.is_blank   = (rdata == CH_SP) || (rdata == CH_TAB);
    assign o_sts.is_digit   = f_digit(rdata);
    assign o_sts.is_dot     = (rdata == CH_DOT);
    assign o_sts.is_dash    = (rdata == CH_DASH);
    assign o_sts.esc_clear  = r_byte != CH_CR && r_byte != CH_TAB && r_byte != CH_BS
                              && r_byte != CH_LF && r_byte == r_esc && eff_len != '0;
    assign o_sts.erase_last = (r_erase == LW'(1));
    assign o_sts.out_valid  = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc      <= ESCAPE_RESET;
            r_len      <= '0;
            r_pos      <= '0;
            r_complete <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) r_esc <= i_cfg_wdata;
            if (i_cmd.take) begin
                r_action <= i_action;
                r_byte   <= i_rx_byte;
                r_mag    <= '0;
                r_neg    <= 1'b0;
                r_kind   <= ECHO_NONE;
                r_ebyte  <= '0;
                r_done   <= 1'b0;
                r_escf   <= 1'b0;
                r_cmdc   <= '0;
                r_ival   <= '0;
                r_perr   <= 1'b0;
            end
            if (i_cmd.rx_exec) begin
                r_complete <= 1'b0;
                r_len      <= eff_len;
                r_pos      <= eff_pos;
                priority if (r_byte == CH_CR || r_byte == CH_TAB) ;
                else if (r_byte == CH_BS) begin
                    if (eff_len != '0) begin
                        r_len  <= eff_len - LW'(1);
                        if (eff_pos > eff_len - LW'(1)) r_pos <= eff_len - LW'(1);
                        r_kind <= ECHO_ERASE;
                    end
                end else if (r_byte == CH_LF) begin
                    r_pos      <= '0;
                    r_complete <= 1'b1;
                    r_kind     <= ECHO_NL;
                    r_done     <= 1'b1;
                end else if (r_byte == r_esc) begin
                    r_pos <= '0;
                    if (eff_len == '0) begin
                        r_complete <= 1'b1;
                        r_done     <= 1'b1;
                        r_escf     <= 1'b1;
                    end else begin
                        r_erase <= eff_len;
                        r_len   <= '0;
                        r_kind  <= ECHO_ERASE;
                    end
                end else if (we) begin
                    r_len   <= eff_len + LW'(1);
                    r_kind  <= ECHO_BYTE;
                    r_ebyte <= r_byte;
                end
            end
            if (i_cmd.adv || i_cmd.set_neg) r_pos <= pos_p1;
            if (i_cmd.set_neg) r_neg <= 1'b1;
            if (i_cmd.set_cmd) r_cmdc <= rdata;
            if (i_cmd.cmd_end) r_cmdc <= '0;
            if (i_cmd.int_err) r_perr <= 1'b1;
            if (i_cmd.acc) begin
                // saturate magnitude above 32 bits
                if (r_mag[32]) r_mag <= r_mag;
                else begin
                    logic [36:0] t;
                    t = {1'b0, r_mag, 3'b0} + {3'b0, r_mag, 1'b0} + 37'(rdata - CH_0);
                    r_mag <= (t > 37'hFFFFFFFF) ? 33'h100000000 : t[32:0];
                end
            end
            if (i_cmd.int_fin) begin
                if (r_neg) r_ival <= (r_mag >= 33'h80000000) ? 32'h80000000
                                     : 32'(33'd0 - r_mag);
                else r_ival <= (r_mag > 33'h7FFFFFFF) ? 32'h7FFFFFFF : r_mag[31:0];
            end
            if (i_cmd.erase_one) begin
                r_erase  <= r_erase - LW'(1);
                r_ovalid <= 1'b1;
            end else if (i_cmd.out_take) r_ovalid <= 1'b1;
            else if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            if (i_cmd.erase_one || i_cmd.out_take) begin
                o_echo_kind   <= i_cmd.erase_one ? ECHO_ERASE : r_kind;
                o_echo_byte   <= r_ebyte;
                o_line_done   <= r_done;
                o_escape_flag <= r_escf;
                o_cmd_char    <= r_cmdc;
                o_int_value   <= r_ival;
                o_param_error <= r_perr;
                o_last        <= !i_cmd.erase_one || r_erase == LW'(1);
            end
        end
    end
    assign o_out_valid = r_ovalid;
endmodule

[rtl/core/command_line_editor_and_scanner_top.sv]
// Top level: console command line editor and token scanner.
// Receive runs the idle, receive and output states; an escape clear emits
// one erase result per character; a fetch reads, then checks, each character.
// One transaction at a time; the result register lets the next item in once loaded.
// Synchronous active-low reset empties the line and restores escape code 27.
`timescale 1ns / 1ps
module command_line_editor_and_scanner_top #(
    parameter int LINE_CAPACITY = cles_pkg::LINE_CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_rx_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_echo_kind,
    output logic [7:0]        o_echo_byte,
    output logic              o_line_done,
    output logic              o_escape_flag,
    output logic [7:0]        o_cmd_char,
    output logic signed [31:0] o_int_value,
    output logic              o_param_error,
    output logic              o_last
);
    import cles_pkg::*;
    t_cmd cmd;
    t_sts sts;

    cles_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_out_ready(i_ready),
        .i_sts(sts), .o_ready(o_ready), .o_cmd(cmd)
    );

    cles_dp #(.LINE_CAPACITY(LINE_CAPACITY)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_action(i_action), .i_rx_byte(i_rx_byte), .i_out_ready(i_ready),
        .i_cmd(cmd), .o_sts(sts), .o_out_valid(o_valid),
        .o_echo_kind(o_echo_kind), .o_echo_byte(o_echo_byte), .o_line_done(o_line_done),
        .o_escape_flag(o_escape_flag), .o_cmd_char(o_cmd_char), .o_int_value(o_int_value),
        .o_param_error(o_param_error), .o_last(o_last)
    );
endmodule

[dv/command_line_editor_and_scanner_top_tb.sv]
// Testbench for the command line editor and scanner: queued driver, monitor, in-bench predictor.
`timescale 1ns / 1ps
module command_line_editor_and_scanner_top_tb;
    import cles_pkg::*;

    localparam int CAP = LINE_CAPACITY_DEF;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  rx_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  echo_kind;
        logic [7:0]  echo_byte;
        logic        line_done;
        logic        escape_flag;
        logic [7:0]  cmd_char;
        logic [31:0] int_value;
        logic        param_error;
        logic        last;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_action = '0;
    logic [7:0] i_rx_byte = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [1:0] o_echo_kind;
    logic [7:0] o_echo_byte;
    logic o_line_done, o_escape_flag, o_param_error, o_last;
    logic [7:0] o_cmd_char;
    logic signed [31:0] o_int_value;

    command_line_editor_and_scanner_top i_dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [7:0] line_buf [CAP];
    int unsigned line_len, rd_pos;
    bit line_ended;
    logic [7:0] esc_code;

    t_item pending_q[$];
    t_res expected_q[$];
    int errors = 0;
    bit idle_on = 1'b1;
    bit hold_rx = 1'b0;

    // ready seen at the last rising edge; lets the driver know the transaction went through
    logic o_ready_q = 1'b0;

    function automatic t_res blank_res();
        t_res r;
        r = '0;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    task automatic predict_receive(logic [7:0] c);
        t_res r;
        r = blank_res();
        if (line_ended) begin
            line_ended = 0;
            line_len = 0;
            rd_pos = 0;
        end
        if (c == CH_CR || c == CH_TAB) begin
            expected_q.push_back(r);
        end else if (c == CH_BS) begin
            if (line_len > 0) begin
                line_len--;
                if (rd_pos > line_len) rd_pos = line_len;
                r.echo_kind = ECHO_ERASE;
            end
            expected_q.push_back(r);
        end else if (c == CH_LF) begin
            rd_pos = 0;
            line_ended = 1;
            r.echo_kind = ECHO_NL;
            r.line_done = 1;
            expected_q.push_back(r);
        end else if (c == esc_code) begin
            if (line_len == 0) begin
                rd_pos = 0;
                line_ended = 1;
                r.line_done = 1;
                r.escape_flag = 1;
                expected_q.push_back(r);
            end else begin
                for (int i = 0; i < line_len; i++) begin
                    r.echo_kind = ECHO_ERASE;
                    r.last = (i + 1 == line_len);
                    expected_q.push_back(r);
                end
                line_len = 0;
                rd_pos = 0;
            end
        end else if (c == CH_NUL || line_len >= CAP) begin
            expected_q.push_back(r);
        end else begin
            line_buf[line_len] = c;
            line_len++;
            r.echo_kind = ECHO_BYTE;
            r.echo_byte = c;
            expected_q.push_back(r);
        end
    endtask

    task automatic predict_scan(t_item it);
        t_res r;
        longint unsigned mag;
        bit neg;
        r = blank_res();
        mag = 0;
        neg = 0;
        if (it.action == ACT_RX) begin
            predict_receive(it.rx_byte);
            return;
        end
        if (it.action == ACT_CMD) begin
            while (rd_pos < line_len && (line_buf[rd_pos] == CH_SP || line_buf[rd_pos] == CH_TAB))
                rd_pos++;
            if (rd_pos < line_len) begin
                r.cmd_char = line_buf[rd_pos];
                rd_pos++;
            end
        end else if (it.action == ACT_INT) begin
            while (rd_pos < line_len && !is_dig(line_buf[rd_pos])
                   && line_buf[rd_pos] != CH_DOT && line_buf[rd_pos] != CH_DASH)
                rd_pos++;
            r.param_error = 1;
            if (rd_pos < line_len && line_buf[rd_pos] != CH_DOT) begin
                neg = (line_buf[rd_pos] == CH_DASH);
                if (!neg || (rd_pos + 1 < line_len && is_dig(line_buf[rd_pos + 1]))) begin
                    if (neg) rd_pos++;
                    while (rd_pos < line_len && is_dig(line_buf[rd_pos])) begin
                        mag = mag * 10 + (line_buf[rd_pos] - CH_0);
                        if (mag > 64'hFFFF_FFFF) mag = 64'h1_0000_0000;
                        rd_pos++;
                    end
                    r.param_error = 0;
                    if (neg) r.int_value = (mag >= 64'h8000_0000) ? 32'h8000_0000
                                                                  : 32'd0 - mag[31:0];
                    else r.int_value = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
                end
            end
        end
        expected_q.push_back(r);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !o_ready_q)) begin
            if (pending_q.size() > 0 && (!idle_on || $urandom_range(99) >= 29)) begin
                i_valid <= 1'b1;
                i_action <= pending_q[0].action;
                i_rx_byte <= pending_q[0].rx_byte;
                void'(pending_q.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_ready <= i_rst_n && !hold_rx && (!idle_on || $urandom_range(99) >= 29);
    end

    always @(posedge i_clk) begin
        o_ready_q <= o_ready;
        if (i_rst_n && i_valid && o_ready)
            predict_scan('{action: i_action, rx_byte: i_rx_byte});
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_echo_kind !== e.echo_kind) begin
                    $error("echo_kind exp %0d got %0d", e.echo_kind, o_echo_kind); errors++; end
                if (o_echo_byte !== e.echo_byte) begin
                    $error("echo_byte exp %0h got %0h", e.echo_byte, o_echo_byte); errors++; end
                if (o_line_done !== e.line_done) begin
                    $error("line_done exp %0b got %0b", e.line_done, o_line_done); errors++; end
                if (o_escape_flag !== e.escape_flag) begin
                    $error("escape_flag exp %0b got %0b", e.escape_flag, o_escape_flag);
                    errors++;
                end
                if (o_cmd_char !== e.cmd_char) begin
                    $error("cmd_char exp %0h got %0h", e.cmd_char, o_cmd_char); errors++; end
                if (o_int_value !== e.int_value) begin
                    $error("int_value exp %0d got %0d", $signed(e.int_value), o_int_value);
                    errors++;
                end
                if (o_param_error !== e.param_error) begin
                    $error("param_error exp %0b got %0b", e.param_error, o_param_error);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0b got %0b", e.last, o_last); errors++; end
            end
        end
    end

    function automatic logic [7:0] rand_token_char();
        int k;
        k = $urandom_range(9);
        if (k < 5) return CH_0 + 8'($urandom_range(9));
        if (k == 5) return CH_SP;
        if (k == 6) return CH_DASH;
        if (k == 7) return CH_DOT;
        if (k == 8) return CH_TAB;
        return 8'h41 + 8'($urandom_range(25));
    endfunction

    task automatic add_rx(logic [7:0] c);
        pending_q.push_back('{action: ACT_RX, rx_byte: c});
    endtask

    task automatic add_line(string s);
        for (int i = 0; i < s.len(); i++) add_rx(s[i]);
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || i_valid || expected_q.size() > 0) @(posedge i_clk);
        repeat (2 * CAP + 10) @(posedge i_clk);
    endtask

    task automatic write_escape(logic [7:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        esc_code = v;
    endtask

    task automatic random_phase(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 45) add_rx(rand_token_char());
            else if (k < 55) pending_q.push_back('{action: ACT_CMD, rx_byte: 8'($urandom)});
            else if (k < 68) pending_q.push_back('{action: ACT_INT, rx_byte: 8'($urandom)});
            else if (k < 73) add_rx(CH_LF);
            else if (k < 77) add_rx(CH_BS);
            else if (k < 80) add_rx(esc_code);
            else if (k < 95) add_rx(8'($urandom));
            else pending_q.push_back('{action: ACT_NONE, rx_byte: 8'($urandom)});
        end
    endtask

    initial begin
        line_len = 0;
        rd_pos = 0;
        line_ended = 0;
        esc_code = ESCAPE_RESET;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: control bytes, fetch on a partial line, saturation, escape
        add_rx(CH_BS);
        add_rx(ESCAPE_RESET);
        add_line("a -12 .5 -x 9999999999\t\r");
        add_rx(CH_NUL);
        pending_q.push_back('{action: ACT_CMD, rx_byte: 8'hFF});
        for (int i = 0; i < 6; i++) pending_q.push_back('{action: ACT_INT, rx_byte: 8'h00});
        add_rx(CH_BS);
        pending_q.push_back('{action: ACT_NONE, rx_byte: 8'hAA});
        add_rx(ESCAPE_RESET);
        drain();

        // full line overflow, then escape clear of a new one-byte line, fill pressure on output
        add_line("-2147483649 x 2147483648 y 1234567 8");
        add_rx(8'hFF);
        add_rx(CH_LF);
        for (int i = 0; i < 4; i++) pending_q.push_back('{action: ACT_INT, rx_byte: 8'h55});
        pending_q.push_back('{action: ACT_CMD, rx_byte: 8'h00});
        add_rx(8'h80);
        add_rx(ESCAPE_RESET);
        hold_rx = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_rx = 1'b0;
        drain();

        idle_on = 1'b0;
        random_phase(80);
        drain();
        idle_on = 1'b1;
        write_escape(8'h00);
        random_phase(60);
        drain();
        write_escape(CH_LF);
        random_phase(30);
        drain();
        write_escape(8'hFF);
        random_phase(50);
        drain();
        write_escape(8'h71);
        random_phase(50);
        drain();

        if (errors == 0) $display("** command_line_editor_and_scanner_top: PASSED **");
        else $display("** command_line_editor_and_scanner_top: FAILED **");
        $finish;
    end

    initial begin
        #20ms;
        $display("** command_line_editor_and_scanner_top: FAILED **");
        $finish;
    end
endmodule
